FILE: sv/barometer_compensation_defines.svh
// Assertion macros used by the barometer compensation checker.
`ifndef BAROMETER_COMPENSATION_DEFINES_SVH
`define BAROMETER_COMPENSATION_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during rst.
`define BC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, sampled on clk and disabled during rst.
`define BC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: sv/bc_pkg.sv
// Shared types, constants and helpers of the barometer compensation block.
package bc_pkg;

  localparam int unsigned TOffset = 4000;
  localparam int unsigned Half    = 32768;
  localparam int unsigned PScale  = 50000;
  localparam int signed   Mg      = 3038;
  localparam int signed   Mh      = -7357;
  localparam int signed   Mi      = 3791;
  localparam int unsigned DivBits = 32;

  localparam logic [1:0] REG_OSS  = 2'd0;
  localparam logic [1:0] REG_CAL0 = 2'd1;
  localparam logic [1:0] REG_CAL1 = 2'd2;
  localparam logic [1:0] REG_CAL2 = 2'd3;

  typedef struct packed {
    logic        req_type;
    logic [23:0] raw_reading;
  } in_t;

  typedef struct packed {
    logic               result_kind;
    logic signed [15:0] temperature_tenths;
    logic [17:0]        pressure_pa;
    logic               status;
  } out_t;

  typedef enum logic [4:0] {
    T_MUL, T_CHK, T_FIN,
    P_B6, P_M1, P_SQ, P_X2, P_X1, P_X3, P_B3, P_X3B, P_M4, P_B4, P_CHK,
    P_Q, P_M5, P_M6, P_M7, P_X2B, P_FIN
  } step_t;

  typedef struct packed {
    logic  load;
    logic  exec;
    logic  finish;
    step_t step;
  } cmd_t;

  typedef struct packed {
    logic fail;
    logic div_done;
  } sts_t;

  function automatic logic signed [31:0] sext16(input logic [15:0] v);
    sext16 = {{16{v[15]}}, v};
  endfunction

  function automatic logic signed [31:0] zext16(input logic [15:0] v);
    zext16 = {16'd0, v};
  endfunction

endpackage

FILE: sv/bc_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module bc_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic [31:0] quotient,
  output logic        done
);

  logic [31:0] rem;
  logic [31:0] dvs;
  logic [5:0]  cnt;
  logic [32:0] trial;

  assign trial    = {rem, quotient[31]} - {1'b0, dvs};
  assign done     = (cnt == 6'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= 6'(bc_pkg::DivBits);
    end else if (cnt != 6'd0) begin
      cnt <= cnt - 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      quotient <= dividend;
      dvs      <= divisor;
    end else if (cnt != 6'd0) begin
      if (!trial[32]) begin
        rem      <= trial[31:0];
        quotient <= {quotient[30:0], 1'b1};
      end else begin
        rem      <= {rem[30:0], quotient[31]};
        quotient <= {quotient[30:0], 1'b0};
      end
    end
  end

endmodule

FILE: sv/bc_ctrl.sv
// Sequencer that steps the datapath through the compensation formulas.
module bc_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          req_type,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  bc_pkg::sts_t  sts,
  output bc_pkg::cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CALC = 3'b010,
    S_DIV  = 3'b100
  } state_t;

  state_t        state, state_next;
  bc_pkg::step_t step, step_next;
  logic          out_valid_next;
  logic          is_chk, is_fin, finishing, go, accept;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state != S_IDLE);
  assign is_chk    = (step == bc_pkg::T_CHK) || (step == bc_pkg::P_CHK);
  assign is_fin    = (step == bc_pkg::T_FIN) || (step == bc_pkg::P_FIN);
  assign finishing = is_fin || (is_chk && sts.fail);
  assign go        = !finishing || !out_valid || !out_stall;

  always_comb begin
    state_next     = state;
    step_next      = step;
    out_valid_next = out_valid && out_stall;
    cmd.load       = 1'b0;
    cmd.exec       = 1'b0;
    cmd.finish     = 1'b0;
    cmd.step       = step;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.load   = 1'b1;
          state_next = S_CALC;
          step_next  = req_type ? bc_pkg::P_B6 : bc_pkg::T_MUL;
        end
      end
      S_CALC: begin
        if (go) begin
          cmd.exec = 1'b1;
          if (finishing) begin
            cmd.finish     = 1'b1;
            out_valid_next = 1'b1;
            state_next     = S_IDLE;
          end else if (is_chk) begin
            state_next = S_DIV;
          end else begin
            step_next = bc_pkg::step_t'(step + 5'd1);
          end
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          step_next  = bc_pkg::step_t'(step + 5'd1);
          state_next = S_CALC;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= bc_pkg::T_MUL;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      step      <= step_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

FILE: sv/bc_dp.sv
// Datapath: configuration, working registers, shared multiplier and divider.
module bc_dp (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [63:0]   cfg_data,
  input  bc_pkg::in_t   in_data,
  input  bc_pkg::cmd_t  cmd,
  output bc_pkg::sts_t  sts,
  output bc_pkg::out_t  out_data
);

  logic [1:0]  oss;
  logic [63:0] cal0, cal1;
  logic [47:0] cal2;

  logic signed [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
  assign ac1 = bc_pkg::sext16(cal0[15:0]);
  assign ac2 = bc_pkg::sext16(cal0[31:16]);
  assign ac3 = bc_pkg::sext16(cal0[47:32]);
  assign ac4 = bc_pkg::zext16(cal0[63:48]);
  assign ac5 = bc_pkg::zext16(cal1[15:0]);
  assign ac6 = bc_pkg::zext16(cal1[31:16]);
  assign b1  = bc_pkg::sext16(cal1[47:32]);
  assign b2  = bc_pkg::sext16(cal1[63:48]);
  assign mc  = bc_pkg::sext16(cal2[31:16]);
  assign md  = bc_pkg::sext16(cal2[47:32]);

  logic               kind;
  logic [23:0]        raw;
  logic signed [31:0] b5, b6, sq, x1, x2, x3, b3, pv;
  logic [31:0]        b4, prod;
  logic               negq, shq;

  logic [31:0]        mul_a, mul_b;
  logic               mul_en;
  logic signed [31:0] sprod, den, mcx, t_x2, t_b5, t_val, p_q, p_fin;
  logic [31:0]        up, den_mag, mc_mag, quo, div_num, div_dvs;
  logic               div_start, div_done, fail;
  logic [15:0]        temp_sat;
  logic [17:0]        pres_sat;

  assign sprod   = $signed(prod);
  assign den     = (sprod >>> 15) + md;
  assign den_mag = den[31] ? 32'(-den) : den;
  assign mcx     = mc <<< 11;
  assign mc_mag  = mcx[31] ? 32'(-mcx) : mcx;
  assign up      = 32'(raw >> (4'd8 - {2'b00, oss}));

  always_comb begin
    fail = 1'b0;
    if (cmd.step == bc_pkg::T_CHK) begin
      fail = (den == 32'sd0);
    end else if (cmd.step == bc_pkg::P_CHK) begin
      fail = (b4 == 32'd0);
    end
  end

  assign div_start = cmd.exec && !fail &&
                     ((cmd.step == bc_pkg::T_CHK) || (cmd.step == bc_pkg::P_CHK));
  assign div_num   = (cmd.step == bc_pkg::T_CHK) ? mc_mag :
                     (prod[31] ? prod : {prod[30:0], 1'b0});
  assign div_dvs   = (cmd.step == bc_pkg::T_CHK) ? den_mag : b4;

  bc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (div_dvs),
    .quotient (quo),
    .done     (div_done)
  );

  assign sts.fail     = fail;
  assign sts.div_done = div_done;

  assign t_x2  = negq ? -$signed(quo) : $signed(quo);
  assign t_b5  = x1 + t_x2;
  assign t_val = (t_b5 + 32'sd8) >>> 4;
  assign temp_sat = (t_val > 32'sd32767)  ? 16'h7FFF :
                    (t_val < -32'sd32768) ? 16'h8000 : t_val[15:0];

  assign p_q   = shq ? $signed({quo[30:0], 1'b0}) : $signed(quo);
  assign p_fin = pv + ((x1 + x2 + 32'(bc_pkg::Mi)) >>> 4);
  assign pres_sat = p_fin[31]              ? 18'd0 :
                    (p_fin > 32'sd262143)  ? 18'h3FFFF : p_fin[17:0];

  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    case (cmd.step)
      bc_pkg::T_MUL: begin
        mul_a = 32'(bc_pkg::zext16(raw[15:0]) - ac6);
        mul_b = ac5;
      end
      bc_pkg::P_M1: begin mul_a = b6;  mul_b = b6; end
      bc_pkg::P_SQ: begin mul_a = ac2; mul_b = b6; end
      bc_pkg::P_X2: begin mul_a = b2;  mul_b = sq; end
      bc_pkg::P_X1: begin mul_a = ac3; mul_b = b6; end
      bc_pkg::P_X3: begin mul_a = b1;  mul_b = sq; end
      bc_pkg::P_M4: begin
        mul_a = ac4;
        mul_b = 32'(x3 + 32'(bc_pkg::Half));
      end
      bc_pkg::P_B4: begin
        mul_a = up - b3;
        mul_b = 32'(bc_pkg::PScale) >> oss;
      end
      bc_pkg::P_M5: begin mul_a = pv >>> 8; mul_b = pv >>> 8; end
      bc_pkg::P_M6: begin mul_a = prod; mul_b = 32'(bc_pkg::Mg); end
      bc_pkg::P_M7: begin mul_a = 32'(bc_pkg::Mh); mul_b = pv; end
      default: mul_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      oss  <= '0;
      cal0 <= '0;
      cal1 <= '0;
      cal2 <= '0;
      b5   <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          bc_pkg::REG_OSS:  oss  <= cfg_data[1:0];
          bc_pkg::REG_CAL0: cal0 <= cfg_data;
          bc_pkg::REG_CAL1: cal1 <= cfg_data;
          bc_pkg::REG_CAL2: cal2 <= cfg_data[47:0];
          default: ;
        endcase
      end
      if (cmd.finish && cmd.step == bc_pkg::T_FIN) begin
        b5 <= t_b5;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind <= in_data.req_type;
      raw  <= in_data.raw_reading;
    end
    if (cmd.exec && mul_en) begin
      prod <= 32'(mul_a * mul_b);
    end
    if (cmd.exec) begin
      case (cmd.step)
        bc_pkg::T_CHK: begin
          x1   <= sprod >>> 15;
          negq <= mcx[31] ^ den[31];
        end
        bc_pkg::P_B6:  b6 <= b5 - 32'(bc_pkg::TOffset);
        bc_pkg::P_SQ:  sq <= sprod >>> 12;
        bc_pkg::P_X2:  x2 <= sprod >>> 11;
        bc_pkg::P_X1:  x1 <= sprod >>> 11;
        bc_pkg::P_X3: begin
          x3 <= (ac1 <<< 2) + x1 + x2;
          x1 <= sprod >>> 13;
        end
        bc_pkg::P_B3: begin
          b3 <= ((x3 <<< oss) + 32'sd2) >>> 2;
          x2 <= sprod >>> 16;
        end
        bc_pkg::P_X3B: x3 <= (x1 + x2 + 32'sd2) >>> 2;
        bc_pkg::P_B4:  b4 <= prod >> 15;
        bc_pkg::P_CHK: shq <= prod[31];
        bc_pkg::P_Q:   pv <= p_q;
        bc_pkg::P_M7:  x1 <= sprod >>> 16;
        bc_pkg::P_X2B: x2 <= sprod >>> 16;
        default: ;
      endcase
    end
    if (cmd.finish) begin
      out_data.result_kind        <= kind;
      out_data.status             <= fail;
      out_data.temperature_tenths <= (!kind && !fail) ? $signed(temp_sat) : 16'sd0;
      out_data.pressure_pa        <= (kind && !fail) ? pres_sat : 18'd0;
    end
  end

endmodule

FILE: sv/barometer_compensation.sv
// Top level of the barometer compensation block.
//
//   Channel  Direction  Handshake              Payload
//   in       input      in_valid / in_stall    in_data (bc_pkg::in_t)
//   out      output     out_valid / out_stall  out_data (bc_pkg::out_t)
//   cfg      input      cfg_we                 cfg_index, cfg_data
//
// A temperature request and a pressure request each step through their own formulas;
// the 32-bit bit-serial divider dominates; the other steps use the multiplier or plain logic.
// A zero divisor ends a temperature or pressure request at its check step, before the divider starts.
// Reset clears the configuration, the kept B5 term and all control state.
// A finished result waits in the output register; a new request is taken meanwhile,
// and its own completion holds until the previous result has been taken.
module barometer_compensation (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  bc_pkg::in_t   in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output bc_pkg::out_t  out_data,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [63:0]   cfg_data
);

  bc_pkg::cmd_t cmd;
  bc_pkg::sts_t sts;

  bc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .req_type  (in_data.req_type),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  bc_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data)
  );

endmodule

FILE: sv/bc_checker.sv
// Port-level checker for the barometer compensation block, with its bind.
`include "barometer_compensation_defines.svh"

module bc_checker (
  input logic         clk,
  input logic         rst,
  input logic         in_valid,
  input logic         in_stall,
  input logic         out_valid,
  input logic         out_stall,
  input bc_pkg::out_t out_data
);

  logic zero_payload;

  assign zero_payload = (out_data.temperature_tenths == 16'sd0) &&
                        (out_data.pressure_pa == 18'd0);

  `BC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))
  `BC_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
  `BC_ASSERT_NOW(a_fail_zero, out_valid && out_data.status, zero_payload)
  `BC_ASSERT_NOW(a_temp_no_pres, out_valid && !out_data.result_kind, out_data.pressure_pa == 18'd0)

endmodule

bind barometer_compensation bc_checker u_bc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

FILE: tb/tb_top.sv
// Testbench for the barometer compensation block: directed and random requests checked against a predictor.
module tb_top;

  class comp_board;
    logic [1:0] oss;
    logic [63:0] cal0, cal1;
    logic [47:0] cal2;
    logic signed [31:0] b5;
    bc_pkg::out_t pending[$];
    int errors;

    function new();
      oss = 0; cal0 = 0; cal1 = 0; cal2 = 0; b5 = 0; errors = 0;
    endfunction

    function logic signed [31:0] s16(logic [63:0] w, int pos);
      logic [15:0] v;
      v = w[pos +: 16];
      return {{16{v[15]}}, v};
    endfunction

    function logic signed [31:0] u16(logic [63:0] w, int pos);
      return {16'd0, w[pos +: 16]};
    endfunction

    function void note_request(bc_pkg::in_t r);
      bc_pkg::out_t o;
      logic signed [31:0] ut, ac5, ac6, mc, md, x1, x2, x3, den, t, ac1, ac2, ac3;
      logic signed [31:0] bb1, bb2, b6, sq, b3, p;
      logic [31:0] ac4, up, b4, b7, q;
      o = '0;
      o.result_kind = r.req_type;
      if (!r.req_type) begin
        ut = {16'd0, r.raw_reading[15:0]};
        ac5 = u16(cal1, 0); ac6 = u16(cal1, 16);
        mc = s16({16'd0, cal2}, 16); md = s16({16'd0, cal2}, 32);
        x1 = ((ut - ac6) * ac5) >>> 15;
        den = x1 + md;
        if (den == 0) begin
          o.status = 1;
        end else begin
          x2 = (mc * 32'sd2048) / den;
          b5 = x1 + x2;
          t = (b5 + 8) >>> 4;
          if (t > 32767) t = 32767;
          if (t < -32768) t = -32768;
          o.temperature_tenths = t[15:0];
        end
      end else begin
        ac1 = s16(cal0, 0); ac2 = s16(cal0, 16); ac3 = s16(cal0, 32);
        ac4 = u16(cal0, 48);
        bb1 = s16(cal1, 32); bb2 = s16(cal1, 48);
        up = {8'd0, r.raw_reading} >> (8 - oss);
        b6 = b5 - 32'sd4000;
        sq = (b6 * b6) >>> 12;
        x1 = (bb2 * sq) >>> 11;
        x2 = (ac2 * b6) >>> 11;
        x3 = x1 + x2;
        b3 = ac1 * 4 + x3;
        b3 = b3 <<< oss;
        b3 = (b3 + 2) >>> 2;
        x1 = (ac3 * b6) >>> 13;
        x2 = (bb1 * sq) >>> 16;
        x3 = (x1 + x2 + 2) >>> 2;
        b4 = (ac4 * (x3 + 32'sd32768)) >> 15;
        b7 = (up - b3) * (32'd50000 >> oss);
        if (b4 == 0) begin
          o.status = 1;
        end else begin
          if (b7 < 32'h80000000) q = (b7 << 1) / b4;
          else q = (b7 / b4) << 1;
          p = q;
          t = p >>> 8;
          x1 = t * t;
          x1 = (x1 * 32'sd3038) >>> 16;
          x2 = (-32'sd7357 * p) >>> 16;
          p = p + ((x1 + x2 + 32'sd3791) >>> 4);
          if (p < 0) p = 0;
          if (p > 262143) p = 262143;
          o.pressure_pa = p[17:0];
        end
      end
      pending.push_back(o);
    endfunction

    function void check_result(bc_pkg::out_t a);
      bc_pkg::out_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, a);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (a.result_kind !== e.result_kind || a.temperature_tenths !== e.temperature_tenths ||
          a.pressure_pa !== e.pressure_pa || a.status !== e.status) begin
        $display("%0t: mismatch expected kind %0d temp %0d pa %0d st %0d, ",
          $time, e.result_kind, e.temperature_tenths, e.pressure_pa, e.status,
          "actual kind %0d temp %0d pa %0d st %0d",
          a.result_kind, a.temperature_tenths, a.pressure_pa, a.status);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic in_valid = 0, in_stall, out_valid, out_stall = 0;
  bc_pkg::in_t in_data = '0;
  bc_pkg::out_t out_data;
  logic cfg_we = 0;
  logic [1:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;
  comp_board board = new();
  int idle_cycles = 0, n_temp = 0, n_pres = 0, stall_left = 0;
  bit stall_hold = 0;

  always #5 clk = ~clk;

  barometer_compensation u_dut (.*);

  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
    return $urandom_range(0, 2);
  endfunction

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) board.check_result(out_data);
    if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, stall_hold ? 30 : 3) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= gap_len();
    end else begin
      out_stall <= 1'b0;
    end
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 2000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [63:0] val);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    @(posedge clk);
    case (idx)
      bc_pkg::REG_OSS:  board.oss = val[1:0];
      bc_pkg::REG_CAL0: board.cal0 = val;
      bc_pkg::REG_CAL1: board.cal1 = val;
      default:          board.cal2 = val[47:0];
    endcase
  endtask

  task automatic send(logic kind, logic [23:0] raw);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1;
    in_data <= '{req_type: kind, raw_reading: raw};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_request(in_data);
    if (kind) n_pres++; else n_temp++;
  endtask

  task automatic drain();
    in_valid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  function automatic logic [15:0] rnd16(int lo, int hi);
    return 16'($urandom_range(lo, hi));
  endfunction

  task automatic typical_cal();
    write_reg(bc_pkg::REG_CAL0, {rnd16(30000, 36000),
                                 16'($signed(-$urandom_range(15000, 14000))),
                                 16'($signed(-$urandom_range(1000, 1300))),
                                 rnd16(7000, 9000)});
    write_reg(bc_pkg::REG_CAL1, {rnd16(30, 60), rnd16(4000, 7000), rnd16(20000, 32000),
                                 rnd16(20000, 28000)});
    write_reg(bc_pkg::REG_CAL2, {16'($signed(-$urandom_range(0, 3000)) + 16'd3000),
                                 16'($signed(-$urandom_range(10000, 12000))), 16'h8000});
  endtask

  initial begin
    logic [23:0] r;
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // Pressure before any temperature, with all-zero calibration (zero divisors).
    send(1, 24'hFFFFFF);
    send(0, 24'h000000);
    send(0, 24'hFFFFFF);
    drain();
    write_reg(bc_pkg::REG_OSS, 2'd3);
    write_reg(bc_pkg::REG_CAL0, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(bc_pkg::REG_CAL1, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(bc_pkg::REG_CAL2, 48'hFFFF_FFFF_FFFF);
    send(0, 24'hAB0000); send(0, 24'h00FFFF); send(1, 24'hFFFFFF); send(1, 24'h000000);
    drain();
    write_reg(bc_pkg::REG_CAL0, 64'h8000_8000_8000_0000);
    write_reg(bc_pkg::REG_CAL1, 64'h8000_8000_0000_0001);
    write_reg(bc_pkg::REG_CAL2, 48'h8000_7FFF_0000);
    send(0, 24'h001234); send(1, 24'h800000); send(0, 24'h000000); send(1, 24'h7FFFFF);
    drain();
    for (int ph = 0; ph < 12; ph++) begin
      write_reg(bc_pkg::REG_OSS, 2'($urandom_range(0, 3)));
      if (ph % 4 == 3) begin
        write_reg(bc_pkg::REG_CAL0, {$urandom, $urandom});
        write_reg(bc_pkg::REG_CAL1, {$urandom, $urandom});
        write_reg(bc_pkg::REG_CAL2, {16'($urandom), $urandom});
      end else begin
        typical_cal();
      end
      stall_hold = (ph % 3 == 1);
      for (int i = 0; i < 90; i++) begin
        if ($urandom_range(0, 2) == 0 || ph % 4 == 3) r = 24'($urandom);
        else if ($urandom_range(0, 1)) r = {8'($urandom), rnd16(24000, 32000)};
        else r = 24'($urandom_range(24'h500000, 24'hB00000));
        send(1'($urandom_range(0, 1)), r);
      end
      drain();
    end
    $display("Covered %0d temperature and %0d pressure requests over 15 settings.",
             n_temp, n_pres);
    if (board.errors == 0 && board.pending.size() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule

FILE: filelist.f
+incdir+sv
sv/bc_pkg.sv
sv/bc_div.sv
sv/bc_ctrl.sv
sv/bc_dp.sv
sv/barometer_compensation.sv
sv/bc_checker.sv
tb/tb_top.sv
